// ===== sv/dipa_pkg.sv =====
// Package for the dotted IPv4 address parser: types, codes and character constants.
package dipa_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BLANK = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
    localparam logic [31:0] MAX_BYTE  = 32'h0000_00FF;
    localparam logic [31:0] MAX_HALF  = 32'h0000_FFFF;
    localparam logic [31:0] MAX_24BIT = 32'h00FF_FFFF;

    localparam int unsigned NUM_PARTS = 4;

    typedef enum logic [2:0] {
        PH_START,
        PH_AFTER_ZERO,
        PH_HEX_FIRST,
        PH_DIGITS,
        PH_DONE,
        PH_ERROR
    } phase_t;

    typedef enum logic [1:0] {
        BASE_DEC,
        BASE_OCT,
        BASE_HEX
    } base_t;

    // Classification of one string byte, produced by the front and used by the back.
    typedef struct packed {
        logic       nul;      // string terminator
        logic       space;    // 09..0D or 20
        logic       blank;    // exactly 20
        logic       dot;
        logic       hex_x;    // x or X
        logic       zero_ch;  // the digit 0
        logic       nz_dec;   // digits 1..9
        logic       dec;      // digits 0..9
        logic       oct;      // digits 0..7
        logic       hexd;     // 0..9, a..f, A..F
        logic [3:0] dval;     // digit value when any digit flag is set
    } char_class_t;

endpackage

// ===== sv/dotted_ipv4_address_parser.sv =====
// Top level of the dotted IPv4 address parser: front, queue and back wired together.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+--------------------------------
//  in      | in  | in_valid / in_ready  | char_byte[7:0]
//  out     | out | out_valid / out_ready| address[31:0], refused
//
// One byte per cycle is taken while the queue has room; a word passes the front
// register, queue and back, and its result is registered when the back takes its
// zero byte; a result still waiting with ready low holds that zero byte back.
// The back end's parse step (shift-add by 8, 10 or 16 plus wrap compare) is
// the per-cycle limit. Reset puts the parser at the start of a fresh string.
// Only a zero byte needs a free result register; other bytes flow on while a
// result waits, and the two-word queue lets the front keep accepting.
module dotted_ipv4_address_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] address,
    output logic        refused
);

    // classified words from the front into the queue
    logic                  f_valid;
    logic                  f_ready;
    dipa_pkg::char_class_t f_cls;

    // queue head into the back end
    logic                  q_valid;
    logic                  q_ready;
    dipa_pkg::char_class_t q_cls;

    // Classify each incoming byte and register the classification.
    dipa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_byte (char_byte),
        .cls_valid (f_valid),
        .cls_ready (f_ready),
        .cls       (f_cls)
    );

    // Decouple the front from stalls on the result side.
    dipa_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_cls),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_cls)
    );

    // Advance the parse state and emit a result on each zero byte.
    dipa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls_valid (q_valid),
        .cls_ready (q_ready),
        .cls       (q_cls),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .address   (address),
        .refused   (refused)
    );

endmodule

// ===== sv/dipa_front.sv =====
// Front stage: accept string bytes, classify them and register the classification.
module dipa_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            char_byte,
    output logic                  cls_valid,
    input  logic                  cls_ready,
    output dipa_pkg::char_class_t cls
);

    logic                  valid_reg;
    logic                  valid_next;
    dipa_pkg::char_class_t cls_reg;
    dipa_pkg::char_class_t cls_next;
    logic                  is_letter;

    always_comb
    begin
        is_letter = ((char_byte >= dipa_pkg::CH_LA) && (char_byte <= dipa_pkg::CH_LF))
                 || ((char_byte >= dipa_pkg::CH_UA) && (char_byte <= dipa_pkg::CH_UF));
        cls_next.nul     = (char_byte == dipa_pkg::CH_NUL);
        cls_next.space   = ((char_byte >= dipa_pkg::CH_TAB) && (char_byte <= dipa_pkg::CH_CR))
                        || (char_byte == dipa_pkg::CH_BLANK);
        cls_next.blank   = (char_byte == dipa_pkg::CH_BLANK);
        cls_next.dot     = (char_byte == dipa_pkg::CH_DOT);
        cls_next.hex_x   = (char_byte == dipa_pkg::CH_LX) || (char_byte == dipa_pkg::CH_UX);
        cls_next.zero_ch = (char_byte == dipa_pkg::CH_0);
        cls_next.nz_dec  = (char_byte >= dipa_pkg::CH_1) && (char_byte <= dipa_pkg::CH_9);
        cls_next.dec     = (char_byte >= dipa_pkg::CH_0) && (char_byte <= dipa_pkg::CH_9);
        cls_next.oct     = (char_byte >= dipa_pkg::CH_0) && (char_byte <= dipa_pkg::CH_7);
        cls_next.hexd    = cls_next.dec || is_letter;
        // letters a/A sit at low nibble 1, so add 9 to reach 10
        cls_next.dval    = is_letter ? (char_byte[3:0] + 4'd9) : char_byte[3:0];
    end

    assign in_ready   = !valid_reg || cls_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cls_reg <= cls_next;
        end
    end

    assign cls_valid = valid_reg;
    assign cls       = cls_reg;

endmodule

// ===== sv/dipa_queue.sv =====
// Two-word queue between the front and the back.
module dipa_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_valid,
    output logic                  wr_ready,
    input  dipa_pkg::char_class_t wr_data,
    output logic                  rd_valid,
    input  logic                  rd_ready,
    output dipa_pkg::char_class_t rd_data
);

    dipa_pkg::char_class_t mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== sv/dipa_back.sv =====
// Back end: parse state machine, part store, final range check and result register.
module dipa_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cls_valid,
    output logic                  cls_ready,
    input  dipa_pkg::char_class_t cls,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [31:0]           address,
    output logic                  refused
);

    dipa_pkg::phase_t phase_reg;
    dipa_pkg::phase_t phase_next;
    dipa_pkg::base_t  base_reg;
    dipa_pkg::base_t  base_next;
    dipa_pkg::base_t  dig_base;
    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic        seen_reg;
    logic        seen_next;
    logic [2:0]  count_reg;
    logic [2:0]  count_next;
    logic [31:0] parts_reg [dipa_pkg::NUM_PARTS];
    logic        store_en;
    logic        start_reg;
    logic        start_next;
    logic        lone_reg;
    logic        lone_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] address_reg;
    logic        refused_reg;

    logic        step;
    logic        dig_ok;
    logic [31:0] scaled;
    logic [31:0] acc_new;

    // finish path
    logic        fin_ok;
    logic [31:0] fin_addr;
    logic        app;
    logic [31:0] app_val;
    logic [2:0]  cnt_f;
    logic [31:0] p0;
    logic [31:0] p1;
    logic [31:0] p2;
    logic [31:0] p3;
    logic [31:0] v;

    // Terminator waits for a free result slot; other bytes never stall.
    assign cls_ready = !cls.nul || !out_valid_reg || out_ready;
    assign step      = cls_valid && cls_ready;

    assign dig_base = (phase_reg == dipa_pkg::PH_AFTER_ZERO) ? dipa_pkg::BASE_OCT : base_reg;

    always_comb
    begin
        unique case (dig_base)
            dipa_pkg::BASE_HEX:
            begin
                dig_ok = cls.hexd;
                scaled = {acc_reg[27:0], 4'b0000};
            end
            dipa_pkg::BASE_OCT:
            begin
                dig_ok = cls.oct;
                scaled = {acc_reg[28:0], 3'b000};
            end
            default:
            begin
                dig_ok = cls.dec;
                scaled = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0};
            end
        endcase
        acc_new = scaled + {28'd0, cls.dval};
    end

    // Parse state machine, one byte per step.
    always_comb
    begin
        logic run_dig;
        logic eff_seen;
        run_dig    = 1'b0;
        eff_seen   = seen_reg;
        phase_next = phase_reg;
        base_next  = base_reg;
        acc_next   = acc_reg;
        seen_next  = seen_reg;
        count_next = count_reg;
        start_next = start_reg;
        lone_next  = lone_reg;
        store_en   = 1'b0;
        if (step)
        begin
            if (cls.nul)
            begin
                phase_next = dipa_pkg::PH_START;
                base_next  = dipa_pkg::BASE_DEC;
                acc_next   = 32'd0;
                seen_next  = 1'b0;
                count_next = 3'd0;
                start_next = 1'b1;
                lone_next  = 1'b0;
            end
            else if (start_reg && cls.blank)
            begin
                start_next = 1'b0;
                lone_next  = 1'b1;
                phase_next = dipa_pkg::PH_ERROR;
            end
            else
            begin
                start_next = 1'b0;
                lone_next  = 1'b0;
                unique case (phase_reg)
                    dipa_pkg::PH_START:
                    begin
                        if (cls.zero_ch)
                        begin
                            acc_next   = 32'd0;
                            phase_next = dipa_pkg::PH_AFTER_ZERO;
                        end
                        else if (cls.nz_dec)
                        begin
                            base_next  = dipa_pkg::BASE_DEC;
                            acc_next   = {28'd0, cls.dval};
                            seen_next  = 1'b1;
                            phase_next = dipa_pkg::PH_DIGITS;
                        end
                        else
                        begin
                            phase_next = dipa_pkg::PH_ERROR;
                        end
                    end
                    dipa_pkg::PH_AFTER_ZERO:
                    begin
                        if (cls.hex_x)
                        begin
                            base_next  = dipa_pkg::BASE_HEX;
                            phase_next = dipa_pkg::PH_HEX_FIRST;
                        end
                        else
                        begin
                            base_next  = dipa_pkg::BASE_OCT;
                            seen_next  = 1'b1;
                            eff_seen   = 1'b1;
                            phase_next = dipa_pkg::PH_DIGITS;
                            run_dig    = 1'b1;
                        end
                    end
                    dipa_pkg::PH_HEX_FIRST:
                    begin
                        if (cls.hexd)
                        begin
                            acc_next   = {28'd0, cls.dval};
                            seen_next  = 1'b1;
                            phase_next = dipa_pkg::PH_DIGITS;
                        end
                        else
                        begin
                            phase_next = dipa_pkg::PH_ERROR;
                        end
                    end
                    dipa_pkg::PH_DIGITS:
                    begin
                        run_dig = 1'b1;
                    end
                    dipa_pkg::PH_DONE:
                    begin
                        phase_next = dipa_pkg::PH_DONE;
                    end
                    default:
                    begin
                        phase_next = dipa_pkg::PH_ERROR;
                    end
                endcase

                if (run_dig)
                begin
                    if (dig_ok)
                    begin
                        // a wrapped value below the old one refuses the digit
                        if (acc_new < acc_reg)
                        begin
                            phase_next = dipa_pkg::PH_ERROR;
                        end
                        else
                        begin
                            acc_next  = acc_new;
                            seen_next = 1'b1;
                        end
                    end
                    else if (!eff_seen)
                    begin
                        phase_next = dipa_pkg::PH_ERROR;
                    end
                    else if (count_reg[2])
                    begin
                        phase_next = dipa_pkg::PH_ERROR;
                    end
                    else
                    begin
                        store_en   = 1'b1;
                        count_next = count_reg + 3'd1;
                        if (cls.dot)
                        begin
                            phase_next = dipa_pkg::PH_START;
                            base_next  = dipa_pkg::BASE_DEC;
                            acc_next   = 32'd0;
                            seen_next  = 1'b0;
                        end
                        else if (cls.space)
                        begin
                            phase_next = dipa_pkg::PH_DONE;
                        end
                        else
                        begin
                            phase_next = dipa_pkg::PH_ERROR;
                        end
                    end
                end
            end
        end
    end

    // Finish: append the open part, range-check, assemble, swap to network order.
    always_comb
    begin
        app     = (phase_reg == dipa_pkg::PH_AFTER_ZERO) || (phase_reg == dipa_pkg::PH_DIGITS);
        app_val = (phase_reg == dipa_pkg::PH_DIGITS) ? acc_reg : 32'd0;
        cnt_f   = count_reg + {2'd0, app};
        p0 = (app && count_reg == 3'd0) ? app_val : parts_reg[0];
        p1 = (app && count_reg == 3'd1) ? app_val : parts_reg[1];
        p2 = (app && count_reg == 3'd2) ? app_val : parts_reg[2];
        p3 = (app && count_reg == 3'd3) ? app_val : parts_reg[3];
        v      = 32'd0;
        fin_ok = 1'b0;
        case (cnt_f)
            3'd1:
            begin
                v      = p0;
                fin_ok = 1'b1;
            end
            3'd2:
            begin
                v      = {p0[7:0], p1[23:0]};
                fin_ok = (p0 <= dipa_pkg::MAX_BYTE) && (p1 <= dipa_pkg::MAX_24BIT);
            end
            3'd3:
            begin
                v      = {p0[7:0], p1[7:0], p2[15:0]};
                fin_ok = (p0 <= dipa_pkg::MAX_BYTE) && (p1 <= dipa_pkg::MAX_BYTE)
                      && (p2 <= dipa_pkg::MAX_HALF);
            end
            3'd4:
            begin
                v      = {p0[7:0], p1[7:0], p2[7:0], p3[7:0]};
                fin_ok = (p0 <= dipa_pkg::MAX_BYTE) && (p1 <= dipa_pkg::MAX_BYTE)
                      && (p2 <= dipa_pkg::MAX_BYTE) && (p3 <= dipa_pkg::MAX_BYTE);
            end
            default:
            begin
                v      = 32'd0;
                fin_ok = 1'b0;
            end
        endcase
        if (!app && (phase_reg != dipa_pkg::PH_DONE))
        begin
            fin_ok = 1'b0;
        end
        if (lone_reg)
        begin
            fin_ok   = 1'b1;
            fin_addr = 32'd0;
        end
        else
        begin
            fin_addr = fin_ok ? {v[7:0], v[15:8], v[23:16], v[31:24]} : dipa_pkg::ALL_ONES;
        end
    end

    assign out_valid_next = (step && cls.nul) || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= dipa_pkg::PH_START;
            base_reg      <= dipa_pkg::BASE_DEC;
            acc_reg       <= 32'd0;
            seen_reg      <= 1'b0;
            count_reg     <= 3'd0;
            start_reg     <= 1'b1;
            lone_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            base_reg      <= base_next;
            acc_reg       <= acc_next;
            seen_reg      <= seen_next;
            count_reg     <= count_next;
            start_reg     <= start_next;
            lone_reg      <= lone_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            parts_reg[count_reg[1:0]] <= acc_reg;
        end
        if (step && cls.nul)
        begin
            address_reg <= fin_addr;
            refused_reg <= !fin_ok;
        end
    end

    assign out_valid = out_valid_reg;
    assign address   = address_reg;
    assign refused   = refused_reg;

endmodule

// ===== sim/tb_dotted_ipv4_address_parser.sv =====
// Testbench for dotted_ipv4_address_parser: random and directed strings against a local predictor.
`timescale 1ns / 1ps

module tb_dotted_ipv4_address_parser;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_BYTES = 1550;
    localparam int DRAIN_CYCLES = 12;

    // One parsed address as the block reports it.
    typedef struct {
        logic [31:0] addr;
        logic        rejected;
    } parsed_addr_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  char_byte;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] address;
    logic        refused;

    // String bytes waiting to be sent, the string under construction,
    // and the addresses the predictor has worked out but not yet seen.
    logic [7:0]   pending_bytes[$];
    logic [7:0]   draft[$];
    parsed_addr_t expected_addrs[$];

    int errors = 0;
    int cycles = 0;
    int send_gap;
    int send_calm;
    int recv_gap;
    int recv_calm;

    // Predictor state: a private copy of the parser's registers.
    dipa_pkg::phase_t ph;
    dipa_pkg::base_t  base;
    logic [31:0]      acc;
    logic             seen;
    int unsigned      nparts;
    logic [31:0]      parts[dipa_pkg::NUM_PARTS];
    logic             fresh;
    logic             lone;

    dotted_ipv4_address_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_byte (char_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .address   (address),
        .refused   (refused)
    );

    always #2 clk = ~clk;

    //--------------------------------------------------------------------------
    // Address predictor
    //--------------------------------------------------------------------------

    function automatic void clear_parse();
        ph     = dipa_pkg::PH_START;
        base   = dipa_pkg::BASE_DEC;
        acc    = '0;
        seen   = 1'b0;
        nparts = 0;
        fresh  = 1'b1;
        lone   = 1'b0;
    endfunction

    // Value of c as a digit of base b, or -1 when it is not one.
    function automatic int digit_of(logic [7:0] c, dipa_pkg::base_t b);
        if (c >= dipa_pkg::CH_0 && c <= dipa_pkg::CH_9)
        begin
            if (b == dipa_pkg::BASE_OCT && c > dipa_pkg::CH_7)
                return -1;
            return int'(c - dipa_pkg::CH_0);
        end
        if (b != dipa_pkg::BASE_HEX)
            return -1;
        if (c >= dipa_pkg::CH_LA && c <= dipa_pkg::CH_LF)
            return int'(c - dipa_pkg::CH_LA) + 10;
        if (c >= dipa_pkg::CH_UA && c <= dipa_pkg::CH_UF)
            return int'(c - dipa_pkg::CH_UA) + 10;
        return -1;
    endfunction

    function automatic bit is_ws(logic [7:0] c);
        return (c >= dipa_pkg::CH_TAB && c <= dipa_pkg::CH_CR) || c == dipa_pkg::CH_BLANK;
    endfunction

    // Store a finished part; a fifth part poisons the string.
    function automatic bit push_part(logic [31:0] v);
        if (nparts >= dipa_pkg::NUM_PARTS)
        begin
            ph = dipa_pkg::PH_ERROR;
            return 1'b0;
        end
        parts[nparts] = v;
        nparts++;
        return 1'b1;
    endfunction

    // One byte while inside the digits of a part.
    function automatic void take_digit_byte(logic [7:0] c);
        int          d;
        logic [31:0] mul;
        logic [31:0] nxt;
        d = digit_of(c, base);
        if (d >= 0)
        begin
            mul = (base == dipa_pkg::BASE_HEX) ? 32'd16 :
                  (base == dipa_pkg::BASE_OCT) ? 32'd8 : 32'd10;
            nxt = acc * mul + 32'(d);
            // wrapped accumulator going down means overflow
            if (nxt < acc)
            begin
                ph = dipa_pkg::PH_ERROR;
                return;
            end
            acc  = nxt;
            seen = 1'b1;
            return;
        end
        if (!seen)
        begin
            ph = dipa_pkg::PH_ERROR;
            return;
        end
        if (!push_part(acc))
            return;
        if (c == dipa_pkg::CH_DOT)
        begin
            ph   = dipa_pkg::PH_START;
            base = dipa_pkg::BASE_DEC;
            acc  = '0;
            seen = 1'b0;
        end
        else if (is_ws(c))
            ph = dipa_pkg::PH_DONE;
        else
            ph = dipa_pkg::PH_ERROR;
    endfunction

    // Close the string: range-check, pack and swap into network order.
    function automatic bit assemble(output logic [31:0] a);
        logic [31:0] v;
        a = dipa_pkg::ALL_ONES;
        if (lone)
        begin
            a = '0;
            return 1'b1;
        end
        if (ph == dipa_pkg::PH_AFTER_ZERO)
        begin
            if (!push_part('0))
                return 1'b0;
        end
        else if (ph == dipa_pkg::PH_DIGITS)
        begin
            if (!push_part(acc))
                return 1'b0;
        end
        else if (ph != dipa_pkg::PH_DONE)
            return 1'b0;
        case (nparts)
            1: v = parts[0];
            2:
            begin
                if (parts[0] > dipa_pkg::MAX_BYTE || parts[1] > dipa_pkg::MAX_24BIT)
                    return 1'b0;
                v = (parts[0] << 24) | parts[1];
            end
            3:
            begin
                if (parts[0] > dipa_pkg::MAX_BYTE || parts[1] > dipa_pkg::MAX_BYTE ||
                    parts[2] > dipa_pkg::MAX_HALF)
                    return 1'b0;
                v = (parts[0] << 24) | (parts[1] << 16) | parts[2];
            end
            4:
            begin
                if (parts[0] > dipa_pkg::MAX_BYTE || parts[1] > dipa_pkg::MAX_BYTE ||
                    parts[2] > dipa_pkg::MAX_BYTE || parts[3] > dipa_pkg::MAX_BYTE)
                    return 1'b0;
                v = (parts[0] << 24) | (parts[1] << 16) | (parts[2] << 8) | parts[3];
            end
            default: return 1'b0;
        endcase
        a = {v[7:0], v[15:8], v[23:16], v[31:24]};
        return 1'b1;
    endfunction

    // Advance the predictor by one accepted word; a zero byte queues an address.
    function automatic void predict_byte(logic [7:0] c);
        parsed_addr_t r;
        logic [31:0]  a;
        int           d;
        if (c == dipa_pkg::CH_NUL)
        begin
            if (assemble(a))
            begin
                r.addr     = a;
                r.rejected = 1'b0;
            end
            else
            begin
                r.addr     = dipa_pkg::ALL_ONES;
                r.rejected = 1'b1;
            end
            expected_addrs.push_back(r);
            clear_parse();
            return;
        end
        if (fresh)
        begin
            fresh = 1'b0;
            // a single blank might be the whole string
            if (c == dipa_pkg::CH_BLANK)
            begin
                lone = 1'b1;
                ph   = dipa_pkg::PH_ERROR;
                return;
            end
        end
        lone = 1'b0;
        case (ph)
            dipa_pkg::PH_START:
            begin
                if (c == dipa_pkg::CH_0)
                begin
                    acc = '0;
                    ph  = dipa_pkg::PH_AFTER_ZERO;
                end
                else if (c >= dipa_pkg::CH_1 && c <= dipa_pkg::CH_9)
                begin
                    base = dipa_pkg::BASE_DEC;
                    acc  = 32'(c - dipa_pkg::CH_0);
                    seen = 1'b1;
                    ph   = dipa_pkg::PH_DIGITS;
                end
                else
                    ph = dipa_pkg::PH_ERROR;
            end
            dipa_pkg::PH_AFTER_ZERO:
            begin
                if (c == dipa_pkg::CH_LX || c == dipa_pkg::CH_UX)
                begin
                    base = dipa_pkg::BASE_HEX;
                    ph   = dipa_pkg::PH_HEX_FIRST;
                end
                else
                begin
                    base = dipa_pkg::BASE_OCT;
                    seen = 1'b1;
                    ph   = dipa_pkg::PH_DIGITS;
                    take_digit_byte(c);
                end
            end
            dipa_pkg::PH_HEX_FIRST:
            begin
                d = digit_of(c, dipa_pkg::BASE_HEX);
                if (d >= 0)
                begin
                    acc  = 32'(d);
                    seen = 1'b1;
                    ph   = dipa_pkg::PH_DIGITS;
                end
                else
                    ph = dipa_pkg::PH_ERROR;
            end
            dipa_pkg::PH_DIGITS: take_digit_byte(c);
            dipa_pkg::PH_DONE:   ;
            default:             ph = dipa_pkg::PH_ERROR;
        endcase
    endfunction

    //--------------------------------------------------------------------------
    // Stimulus construction
    //--------------------------------------------------------------------------

    // Mostly no gap, some short ones, a few long; now and then a calm stretch
    // with no gaps at all.
    function automatic int pick_gap(ref int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 199);
        if (r == 0)
        begin
            calm = $urandom_range(50, 200);
            return 0;
        end
        if (r < 120)
            return 0;
        if (r < 190)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void draft_text(string s);
        for (int i = 0; i < s.len(); i++)
            draft.push_back(s[i]);
    endfunction

    // Move the draft into the send queue, closed by a zero byte.
    function automatic int commit_draft();
        int n;
        n = draft.size() + 1;
        foreach (draft[i])
            pending_bytes.push_back(draft[i]);
        pending_bytes.push_back(dipa_pkg::CH_NUL);
        draft.delete();
        return n;
    endfunction

    function automatic logic [7:0] pick_ws();
        logic [7:0] w;
        w = $urandom_range(0, 5);
        return (w == 5) ? dipa_pkg::CH_BLANK : dipa_pkg::CH_TAB + w;
    endfunction

    // One address part in a random base, mostly within its field width.
    function automatic void draft_part(logic [31:0] lim);
        logic [63:0] v;
        string       s;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = {32'd0, lim};
            2:       v = {32'd0, lim} + 64'd1;
            3:       v = {32'd0, $urandom()};
            4:       v = {$urandom(), $urandom()} >> $urandom_range(0, 40);
            default: v = {32'd0, $urandom_range(0, lim)};
        endcase
        case ($urandom_range(0, 2))
            0: s = $sformatf("%0d", v);
            1: s = $sformatf("0%0o", v);
            default:
            begin
                s = $sformatf("%0h", v);
                if ($urandom_range(0, 1))
                    s = s.toupper();
                s = $urandom_range(0, 1) ? {"0x", s} : {"0X", s};
            end
        endcase
        draft_text(s);
    endfunction

    // Build one random string and queue it; return the number of words added.
    function automatic int queue_random_string();
        int          kind;
        int          n;
        logic [31:0] lim;
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            // noise: arbitrary nonzero bytes, possibly none
            repeat ($urandom_range(0, 6))
                draft.push_back(8'($urandom_range(1, 255)));
        end
        else if (kind < 12)
        begin
            // leading whitespace, alone or followed by a blank or the digit 1
            draft.push_back($urandom_range(0, 1) ? dipa_pkg::CH_BLANK : pick_ws());
            if ($urandom_range(0, 1))
                draft.push_back($urandom_range(0, 1) ? dipa_pkg::CH_BLANK : dipa_pkg::CH_1);
        end
        else
        begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
            begin
                if (i > 0)
                    draft.push_back(dipa_pkg::CH_DOT);
                if (i < n - 1 || n == 4)
                    lim = dipa_pkg::MAX_BYTE;
                else if (n == 1)
                    lim = dipa_pkg::ALL_ONES;
                else if (n == 2)
                    lim = dipa_pkg::MAX_24BIT;
                else
                    lim = dipa_pkg::MAX_HALF;
                draft_part(lim);
            end
            if ($urandom_range(0, 99) < 15)
            begin
                // trailing whitespace, then junk that must be ignored
                draft.push_back(pick_ws());
                repeat ($urandom_range(0, 4))
                    draft.push_back(8'($urandom_range(1, 255)));
            end
            if ($urandom_range(0, 99) < 12)
            begin
                // break the string: stray byte, dropped byte or an extra part
                case ($urandom_range(0, 2))
                    0: draft.insert($urandom_range(0, draft.size()),
                                    8'($urandom_range(1, 255)));
                    1: draft.delete($urandom_range(0, draft.size() - 1));
                    default: draft_text(".7");
                endcase
            end
        end
        return commit_draft();
    endfunction

    //--------------------------------------------------------------------------
    // Driver: present one word at a time from pending_bytes
    //--------------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            char_byte <= '0;
            send_gap  = 0;
            send_calm = 0;
            clear_parse();
        end
        else
        begin
            // predict on the word the block takes at this edge
            if (in_valid && in_ready)
                predict_byte(char_byte);
            // hold the word while it waits; otherwise advance or idle
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_bytes.size() != 0)
                begin
                    in_valid  <= 1'b1;
                    char_byte <= pending_bytes.pop_front();
                    send_gap  = pick_gap(send_calm);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    //--------------------------------------------------------------------------
    // Monitor: stall the result side and check every address taken
    //--------------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        parsed_addr_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap  = 0;
            recv_calm = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_addrs.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result address %h refused %b",
                             $time, address, refused);
                end
                else
                begin
                    want = expected_addrs.pop_front();
                    if (address !== want.addr)
                    begin
                        errors++;
                        $display("%0t: address expected %h got %h",
                                 $time, want.addr, address);
                    end
                    if (refused !== want.rejected)
                    begin
                        errors++;
                        $display("%0t: refused expected %b got %b",
                                 $time, want.rejected, refused);
                    end
                end
            end
            // drop ready for a random stretch, then raise it again
            if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                recv_gap  = pick_gap(recv_calm);
            end
        end
    end

    // Watchdog: give up well past the slowest legal run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_dotted_ipv4_address_parser NOT OK");
            $finish;
        end
    end

    //--------------------------------------------------------------------------
    // Sequence: reset, directed strings, random strings with a full drain in
    // the middle, then wait out the last addresses and report.
    //--------------------------------------------------------------------------

    initial
    begin
        int sent;
        rst_n = 1'b0;
        sent  = 0;

        // Directed: field extremes, every base, and the corner cases:
        // lone blank, empty string, bare hex prefix, overflow on wrap,
        // trailing whitespace and junk, stray bytes, a fifth part, all ones.
        draft_text("0.0.0.0");            sent += commit_draft();
        draft_text("255.255.255.255");    sent += commit_draft();
        draft_text(" ");                  sent += commit_draft();
        sent += commit_draft();
        draft_text("0x");                 sent += commit_draft();
        draft_text("0X.1");               sent += commit_draft();
        draft_text("4294967295");         sent += commit_draft();
        draft_text("4294967296");         sent += commit_draft();
        draft_text("0xffffffff");         sent += commit_draft();
        draft_text("0XABCDEF12");         sent += commit_draft();
        draft_text("037777777777");       sent += commit_draft();
        draft_text("08");                 sent += commit_draft();
        draft_text("0");                  sent += commit_draft();
        draft_text("1.16777215");         sent += commit_draft();
        draft_text("1.16777216");         sent += commit_draft();
        draft_text("1.2.65535");          sent += commit_draft();
        draft_text("1.2.65536");          sent += commit_draft();
        draft_text("256.1.1.1");          sent += commit_draft();
        draft_text("1.2.3.4.5");          sent += commit_draft();
        draft_text("10.0.0.1 z!");        sent += commit_draft();
        draft_text("10.0.0.1\r\t9");      sent += commit_draft();
        draft_text("10.0.0.1x");          sent += commit_draft();
        draft_text("\t1.2.3.4");          sent += commit_draft();
        draft_text(" 1");                 sent += commit_draft();
        draft_text("1..2");               sent += commit_draft();
        draft_text("0x0.0377.0.0xFe");    sent += commit_draft();
        draft.push_back(8'hFF);
        draft.push_back(8'h80);           sent += commit_draft();

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // random strings up to half the word budget
        while (sent < RANDOM_BYTES / 2)
            sent += queue_random_string();

        // hold the sender until every address so far has come back
        while (pending_bytes.size() != 0 || in_valid || expected_addrs.size() != 0)
            @(negedge clk);

        while (sent < RANDOM_BYTES)
            sent += queue_random_string();

        while (pending_bytes.size() != 0 || in_valid)
            @(negedge clk);
        while (expected_addrs.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("tb_dotted_ipv4_address_parser OK");
        else
            $display("tb_dotted_ipv4_address_parser NOT OK");
        $finish;
    end

endmodule
